/* rtl/core/tdsl_pkg.sv */
// Shared types and constants for the terminal device with scrolling line.
package tdsl_pkg;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_KEY_RD,
        S_SCR_RD,
        S_PRINT2,
        S_SCROLL_WR,
        S_SCROLL_SP,
        S_CLR_RD,
        S_CLR_WR,
        S_DONE
    } t_state;

    // Operation codes carried in the mode field
    typedef enum logic [2:0] {
        OP_BUS_RD    = 3'd0,
        OP_BUS_WR    = 3'd1,
        OP_KEY       = 3'd2,
        OP_TICK      = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_PEEK_SCR  = 3'd5,
        OP_PEEK_KEYS = 3'd6
    } t_op;

    // Bus subdevices
    typedef enum logic [1:0] {
        SUB_KDATA = 2'd0,
        SUB_KSTAT = 2'd1,
        SUB_SDATA = 2'd2,
        SUB_SSTAT = 2'd3
    } t_sub;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_INV  = 2'd2
    } t_status;

    // Screen modes
    typedef enum logic [1:0] {
        SM_NORMAL = 2'd0,
        SM_SCROLL = 2'd1,
        SM_CLEAR  = 2'd2
    } t_smode;

    // Key queue commands, at most one set per cycle
    typedef struct packed {
        logic push;
        logic pop;
        logic peek;
    } t_kq_cmd;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

endpackage

/* rtl/core/tdsl_scrmem.sv */
// Screen line memory: one write port, one registered read port, per-cell valid bits.
module tdsl_scrmem #(
    parameter int LINE_LEN = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [$clog2(LINE_LEN+1)-1:0]      i_waddr,
    input  logic [7:0]                         i_wdata,
    input  logic [$clog2(LINE_LEN+1)-1:0]      i_raddr,
    output logic [7:0]                         o_rdata
);
    localparam int CELLS = LINE_LEN + 1;

    logic [7:0]       r_mem [CELLS];
    logic [CELLS-1:0] r_vld;
    logic [7:0]       r_rdata;
    logic             r_rvld;

    // valid bits: a cell never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
        r_rvld  <= r_vld[i_raddr];
    end

    assign o_rdata = r_rvld ? r_rdata : 8'h00;

endmodule

/* rtl/core/tdsl_keyq.sv */
// Key queue: circular buffer in a memory with head pointer and fill count.
module tdsl_keyq #(
    parameter int LINE_LEN = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tdsl_pkg::t_kq_cmd                  i_cmd,
    input  logic [7:0]                         i_wdata,
    input  logic [$clog2(LINE_LEN+1)-1:0]      i_idx,
    output logic [7:0]                         o_rdata,
    output logic [$clog2(LINE_LEN-1)-1:0]      o_count
);
    localparam int KAW   = $clog2(LINE_LEN);
    localparam int CW    = $clog2(LINE_LEN - 1);
    localparam int IDX_W = $clog2(LINE_LEN + 1);
    localparam logic [KAW:0]   L_WRAP = (KAW+1)'(LINE_LEN);
    localparam logic [KAW-1:0] L_TOP  = KAW'(LINE_LEN - 1);
    localparam logic [CW-1:0]  L_FULL = CW'(LINE_LEN - 2);

    logic [7:0]     r_mem [LINE_LEN];
    logic [KAW-1:0] r_head;
    logic [CW-1:0]  r_count;
    logic [7:0]     r_rdata;
    logic           r_rzero;

    logic [KAW:0]   tail_sum;
    logic [KAW:0]   peek_sum;
    logic [KAW-1:0] tail;
    logic [KAW-1:0] peek_addr;
    logic [KAW-1:0] head_inc;
    logic [KAW-1:0] raddr;
    logic           do_push;
    logic           do_pop;

    // address arithmetic with wrap at the queue depth
    assign tail_sum  = {1'b0, r_head} + (KAW+1)'(r_count);
    assign peek_sum  = {1'b0, r_head} + {1'b0, i_idx[KAW-1:0]};
    assign tail      = (tail_sum >= L_WRAP) ? KAW'(tail_sum - L_WRAP) : tail_sum[KAW-1:0];
    assign peek_addr = (peek_sum >= L_WRAP) ? KAW'(peek_sum - L_WRAP) : peek_sum[KAW-1:0];
    assign head_inc  = (r_head == L_TOP) ? '0 : r_head + 1'b1;
    assign raddr     = i_cmd.pop ? r_head : peek_addr;

    // full queue drops the key, empty queue ignores a pop
    assign do_push = i_cmd.push && (r_count < L_FULL);
    assign do_pop  = i_cmd.pop && (r_count != '0);

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (do_push) begin
            r_count <= r_count + 1'b1;
        end else if (do_pop) begin
            r_head  <= head_inc;
            r_count <= r_count - 1'b1;
        end
    end

    // storage and registered read; cells past the last key read as zero
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[tail] <= i_wdata;
        end
        r_rdata <= r_mem[raddr];
        r_rzero <= i_cmd.peek && (i_idx >= IDX_W'(r_count));
    end

    assign o_rdata = r_rzero ? 8'h00 : r_rdata;
    assign o_count = r_count;

endmodule

/* rtl/core/terminal_device_with_scrolling_line_unit.sv */
// Terminal device top level: word sequencer, screen state and output register.
// Steps: status reads, writes, key presses, plain ticks and screen clears finish in the
// execute state; key pops and peeks in range add a key or screen read state, printable
// writes an end-marker state; a scroll tick adds a write and a space state; a clearing
// tick runs a read/write pair per cell. The idle/execute sequencer holds one word at a
// time, so a new word is not accepted before the last one is through.
// Reset (synchronous, active low) empties the key queue and leaves the screen all zeros.
module terminal_device_with_scrolling_line_unit #(
    parameter int LINE_LEN = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [2:0]                         i_mode,
    input  logic [1:0]                         i_subdevice,
    input  logic [7:0]                         i_char_in,
    input  logic [$clog2(LINE_LEN+1)-1:0]      i_cell_index,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_read_data,
    output logic [1:0]                         o_status
);
    localparam int SAW = $clog2(LINE_LEN + 1);
    localparam int CW  = $clog2(LINE_LEN - 1);
    localparam logic [SAW-1:0] L_LAST = SAW'(LINE_LEN - 1);
    localparam logic [SAW-1:0] L_MAX  = SAW'(LINE_LEN);

    tdsl_pkg::t_state  r_state, n_state;
    tdsl_pkg::t_op     r_op;
    tdsl_pkg::t_sub    r_sub;
    logic [7:0]        r_ch;
    logic [SAW-1:0]    r_idx;

    logic [SAW-1:0]    r_len, n_len;
    logic [SAW-1:0]    r_pos, n_pos;
    logic [SAW-1:0]    r_ci, n_ci;
    tdsl_pkg::t_smode  r_smode, n_smode;
    logic              r_at_end, n_at_end;

    logic              c_fin;
    logic [7:0]        c_data;
    tdsl_pkg::t_status c_st;
    logic [7:0]        r_res_data;
    tdsl_pkg::t_status r_res_st;

    logic              r_out_valid;
    logic [7:0]        r_out_data;
    tdsl_pkg::t_status r_out_st;
    logic              slot_free;
    logic              in_acc;

    logic              scr_we;
    logic [SAW-1:0]    scr_waddr;
    logic [7:0]        scr_wdata;
    logic [SAW-1:0]    scr_raddr;
    logic [7:0]        scr_rdata;

    tdsl_pkg::t_kq_cmd kq_cmd;
    logic [7:0]        kq_rdata;
    logic [CW-1:0]     kq_count;

    logic [SAW-1:0]    pos_inc;
    logic [SAW-1:0]    ci_inc;
    logic              idx_ok;
    logic              d_kpop, d_kpeek, d_speek, d_print, d_scroll, d_clr_go, d_wait;

    // storage units
    tdsl_scrmem #(.LINE_LEN(LINE_LEN)) u_scrmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (scr_we),
        .i_waddr (scr_waddr),
        .i_wdata (scr_wdata),
        .i_raddr (scr_raddr),
        .o_rdata (scr_rdata)
    );

    tdsl_keyq #(.LINE_LEN(LINE_LEN)) u_keyq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (kq_cmd),
        .i_wdata (r_ch),
        .i_idx   (r_idx),
        .o_rdata (kq_rdata),
        .o_count (kq_count)
    );

    // handshake
    assign o_in_ready  = (r_state == tdsl_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_st;

    // decode of the word under execution
    assign pos_inc  = r_pos + 1'b1;
    assign ci_inc   = r_ci + 1'b1;
    assign idx_ok   = (r_idx <= L_MAX);
    assign d_kpop   = (r_op == tdsl_pkg::OP_BUS_RD) && (r_sub == tdsl_pkg::SUB_KDATA)
                      && (kq_count != '0);
    assign d_kpeek  = (r_op == tdsl_pkg::OP_PEEK_KEYS) && idx_ok;
    assign d_speek  = (r_op == tdsl_pkg::OP_PEEK_SCR) && idx_ok;
    assign d_print  = (r_op == tdsl_pkg::OP_BUS_WR) && (r_sub == tdsl_pkg::SUB_SDATA)
                      && (r_smode == tdsl_pkg::SM_NORMAL) && (r_ch != tdsl_pkg::CH_NL);
    assign d_scroll = (r_op == tdsl_pkg::OP_TICK) && (r_smode == tdsl_pkg::SM_SCROLL);
    assign d_clr_go = (r_op == tdsl_pkg::OP_TICK) && (r_smode == tdsl_pkg::SM_CLEAR)
                      && (r_len != '0);
    assign d_wait   = d_kpop || d_kpeek || d_speek || d_print || d_scroll || d_clr_go;

    // result of the current state, and whether the word finishes here
    always_comb begin
        c_fin  = 1'b0;
        c_data = 8'h00;
        c_st   = tdsl_pkg::ST_OK;
        case (r_state)
            tdsl_pkg::S_EXEC: begin
                c_fin = !d_wait;
                case (r_op)
                    tdsl_pkg::OP_BUS_RD: begin
                        case (r_sub)
                            tdsl_pkg::SUB_KDATA: c_st   = tdsl_pkg::ST_BUSY;
                            tdsl_pkg::SUB_KSTAT: c_data = {7'd0, kq_count != '0};
                            tdsl_pkg::SUB_SDATA: c_st   = tdsl_pkg::ST_INV;
                            tdsl_pkg::SUB_SSTAT: c_data = {7'd0, r_smode == tdsl_pkg::SM_NORMAL};
                            default:             c_st   = tdsl_pkg::ST_INV;
                        endcase
                    end
                    tdsl_pkg::OP_BUS_WR: begin
                        if (r_sub != tdsl_pkg::SUB_SDATA) begin
                            c_st = tdsl_pkg::ST_INV;
                        end else if (r_smode != tdsl_pkg::SM_NORMAL) begin
                            c_st = tdsl_pkg::ST_BUSY;
                        end
                    end
                    tdsl_pkg::OP_KEY,
                    tdsl_pkg::OP_TICK,
                    tdsl_pkg::OP_CLEAR: c_st = tdsl_pkg::ST_OK;
                    tdsl_pkg::OP_PEEK_SCR,
                    tdsl_pkg::OP_PEEK_KEYS: c_st = tdsl_pkg::ST_INV;
                    default: c_st = tdsl_pkg::ST_INV;
                endcase
            end
            tdsl_pkg::S_KEY_RD: begin
                c_fin  = 1'b1;
                c_data = kq_rdata;
            end
            tdsl_pkg::S_SCR_RD: begin
                c_fin  = 1'b1;
                c_data = scr_rdata;
            end
            tdsl_pkg::S_PRINT2,
            tdsl_pkg::S_SCROLL_SP: c_fin = 1'b1;
            tdsl_pkg::S_CLR_WR: c_fin = (ci_inc == r_len);
            tdsl_pkg::S_DONE: begin
                c_fin  = 1'b1;
                c_data = r_res_data;
                c_st   = r_res_st;
            end
            default: c_fin = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (c_fin) begin
            n_state = slot_free ? tdsl_pkg::S_IDLE : tdsl_pkg::S_DONE;
        end else begin
            case (r_state)
                tdsl_pkg::S_IDLE: begin
                    if (in_acc) begin
                        n_state = tdsl_pkg::S_EXEC;
                    end
                end
                tdsl_pkg::S_EXEC: begin
                    if (d_kpop || d_kpeek) begin
                        n_state = tdsl_pkg::S_KEY_RD;
                    end else if (d_speek) begin
                        n_state = tdsl_pkg::S_SCR_RD;
                    end else if (d_print) begin
                        n_state = tdsl_pkg::S_PRINT2;
                    end else if (d_scroll) begin
                        n_state = tdsl_pkg::S_SCROLL_WR;
                    end else begin
                        n_state = tdsl_pkg::S_CLR_RD;
                    end
                end
                tdsl_pkg::S_SCROLL_WR: n_state = tdsl_pkg::S_SCROLL_SP;
                tdsl_pkg::S_CLR_RD:    n_state = tdsl_pkg::S_CLR_WR;
                tdsl_pkg::S_CLR_WR:    n_state = tdsl_pkg::S_CLR_RD;
                default:               n_state = r_state;
            endcase
        end
    end

    // memory commands and screen state updates
    always_comb begin
        n_len     = r_len;
        n_pos     = r_pos;
        n_ci      = r_ci;
        n_smode   = r_smode;
        n_at_end  = r_at_end;
        scr_we    = 1'b0;
        scr_waddr = '0;
        scr_wdata = 8'h00;
        scr_raddr = '0;
        kq_cmd    = '0;
        case (r_state)
            tdsl_pkg::S_EXEC: begin
                case (r_op)
                    tdsl_pkg::OP_BUS_RD: kq_cmd.pop = d_kpop;
                    tdsl_pkg::OP_BUS_WR: begin
                        if (d_print) begin
                            scr_we    = 1'b1;
                            scr_waddr = r_len;
                            scr_wdata = r_ch;
                            n_len     = r_len + 1'b1;
                        end else if ((r_sub == tdsl_pkg::SUB_SDATA)
                                     && (r_smode == tdsl_pkg::SM_NORMAL)) begin
                            n_smode = tdsl_pkg::SM_CLEAR;
                        end
                    end
                    tdsl_pkg::OP_KEY: kq_cmd.push = 1'b1;
                    tdsl_pkg::OP_TICK: begin
                        if (d_scroll) begin
                            scr_raddr = pos_inc;
                            n_at_end  = (pos_inc >= r_len);
                        end else if (d_clr_go) begin
                            n_ci = '0;
                        end else if (r_smode == tdsl_pkg::SM_CLEAR) begin
                            n_smode = tdsl_pkg::SM_NORMAL;
                        end
                    end
                    tdsl_pkg::OP_CLEAR: begin
                        scr_we    = 1'b1;
                        scr_waddr = '0;
                        scr_wdata = 8'h00;
                        n_len     = '0;
                        n_smode   = tdsl_pkg::SM_NORMAL;
                    end
                    tdsl_pkg::OP_PEEK_SCR:  scr_raddr   = d_speek ? r_idx : '0;
                    tdsl_pkg::OP_PEEK_KEYS: kq_cmd.peek = d_kpeek;
                    default: kq_cmd = '0;
                endcase
            end
            // end marker after the new character; a full line starts scrolling
            tdsl_pkg::S_PRINT2: begin
                scr_we    = 1'b1;
                scr_waddr = r_len;
                scr_wdata = 8'h00;
                if (r_len == L_LAST) begin
                    n_smode = tdsl_pkg::SM_SCROLL;
                    n_pos   = '0;
                end
            end
            tdsl_pkg::S_SCROLL_WR: begin
                scr_we    = 1'b1;
                scr_waddr = r_pos;
                scr_wdata = r_at_end ? 8'h00 : scr_rdata;
            end
            tdsl_pkg::S_SCROLL_SP: begin
                scr_we    = 1'b1;
                scr_waddr = pos_inc;
                scr_wdata = tdsl_pkg::CH_SP;
                n_pos     = pos_inc;
                if (r_at_end) begin
                    n_len   = r_pos;
                    n_smode = tdsl_pkg::SM_NORMAL;
                end
            end
            // clearing tick: shift the line left one cell per read/write pair
            tdsl_pkg::S_CLR_RD: scr_raddr = ci_inc;
            tdsl_pkg::S_CLR_WR: begin
                scr_we    = 1'b1;
                scr_waddr = r_ci;
                scr_wdata = scr_rdata;
                if (ci_inc == r_len) begin
                    n_len = r_len - 1'b1;
                    if (r_len == SAW'(1)) begin
                        n_smode = tdsl_pkg::SM_NORMAL;
                    end
                end else begin
                    n_ci = ci_inc;
                end
            end
            default: kq_cmd = '0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdsl_pkg::S_IDLE;
            r_len       <= '0;
            r_pos       <= '0;
            r_smode     <= tdsl_pkg::SM_NORMAL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_smode <= n_smode;
            if (c_fin && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word capture, work registers and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= tdsl_pkg::t_op'(i_mode);
            r_sub <= tdsl_pkg::t_sub'(i_subdevice);
            r_ch  <= i_char_in;
            r_idx <= i_cell_index;
        end
        r_ci     <= n_ci;
        r_at_end <= n_at_end;
        if (c_fin) begin
            r_res_data <= c_data;
            r_res_st   <= c_st;
        end
        if (c_fin && slot_free) begin
            r_out_data <= c_data;
            r_out_st   <= c_st;
        end
    end

    // line length never passes the last usable cell
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= L_LAST)
        else $error("screen length out of range");

    // scrolling cell stays inside the line
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_smode == tdsl_pkg::SM_SCROLL) |-> (r_pos < r_len))
        else $error("scroll position past line end");

    // a held result only waits while the output register is occupied
    a_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdsl_pkg::S_DONE) |-> r_out_valid)
        else $error("result held with output register empty");

    // clearing sweep stays inside the line
    a_clr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdsl_pkg::S_CLR_RD) |-> (r_ci < r_len))
        else $error("clearing index past line end");

    // no new word is taken while one is in flight
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdsl_pkg::S_EXEC) |-> !$past(r_state == tdsl_pkg::S_EXEC))
        else $error("execute state repeated");

endmodule
